/* rtl/longest_prefix_match_table_defines.svh */
// Assertion macros shared by the lookup table checks
`ifndef LONGEST_PREFIX_MATCH_TABLE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_TABLE_DEFINES_SVH

// cond in the same cycle
`define LPMT_ASSERT_IMP(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// cond in the cycle after trig
`define LPMT_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* rtl/lpmt_pkg.sv */
// Types and constants of the longest-prefix-match lookup table
package lpmt_pkg;

	localparam int LIMIT_W = 7;
	localparam int PLEN_W  = 6;
	localparam int IN_ADDR_W = 32;
	localparam int LINK_W  = 48;
	localparam int TERM_W  = 16;
	localparam int LEN_W   = 7;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_ADDR_BITS   = 32;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef struct packed {
		logic                 action;
		logic [IN_ADDR_W-1:0] address;
		logic [PLEN_W-1:0]    prefix_length;
		logic [LINK_W-1:0]    link_address;
		logic [TERM_W-1:0]    terminal_id;
	} lpmt_req_t;

	typedef struct packed {
		logic              ok;
		logic [LINK_W-1:0] found_link_address;
		logic [TERM_W-1:0] found_terminal_id;
	} lpmt_res_t;

	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [LEN_W-1:0]  len;
		logic [LINK_W-1:0] link;
		logic [TERM_W-1:0] term;
	} lpmt_tok_t;

	typedef struct packed {
		logic              en;
		logic [LEN_W-1:0]  len;
		logic [LINK_W-1:0] link;
		logic [TERM_W-1:0] term;
	} lpmt_wr_t;

endpackage

/* rtl/longest_prefix_match_table.sv */
// Add: result in the cycle after start; adds may follow every cycle while not busy.
// Lookup: the search walks the row of TABLE_DEPTH entry cells, one cell a cycle,
// through the launch register and then each cell's token register, and busy
// holds the next item off until the result comes. Results cannot be stalled.
// Reset clears the entry count and the limit; entries are not cleared and need
// no sweep, since only entries below the count take part in a lookup.
module longest_prefix_match_table #(
	parameter int TABLE_DEPTH = lpmt_pkg::DEF_TABLE_DEPTH,
	parameter int ADDR_BITS = lpmt_pkg::DEF_ADDR_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  lpmt_pkg::lpmt_req_t          request,
	output logic                         done,
	output lpmt_pkg::lpmt_res_t          result,
	input  logic                         entry_limit_we,
	input  logic [lpmt_pkg::LIMIT_W-1:0] entry_limit
);
	import lpmt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	logic [CNT_W-1:0]     count_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic                 launch_q;
	logic                 busy_q;
	logic                 add_done_q;
	logic                 add_ok_q;

	logic                 accept;
	logic                 full;
	logic [CMP_W-1:0]     active_limit;
	logic [LEN_W-1:0]     plen;
	lpmt_wr_t             wr;
	logic [ADDR_BITS-1:0] wr_prefix;
	lpmt_tok_t            chain [TABLE_DEPTH+1];

	always_comb begin
		accept = start && !busy;
		if ((limit_q == '0) || (CMP_W'(limit_q) > CMP_W'(TABLE_DEPTH))) begin
			active_limit = CMP_W'(TABLE_DEPTH);
		end else begin
			active_limit = CMP_W'(limit_q);
		end
		full = CMP_W'(count_q) >= active_limit;
		plen = LEN_W'(request.prefix_length);
		if (plen > LEN_W'(ADDR_BITS)) begin
			plen = LEN_W'(ADDR_BITS);
		end
		wr.en     = accept && (request.action == ACT_ADD) && !full;
		wr.len    = plen;
		wr.link   = request.link_address;
		wr.term   = request.terminal_id;
		wr_prefix = ADDR_BITS'(request.address);
	end

	assign chain[0] = '{valid: launch_q, hit: 1'b0, len: '0, link: '0, term: '0};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lpmt_cell #(
			.ADDR_BITS(ADDR_BITS),
			.CNT_W(CNT_W),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.wr(wr),
			.wr_prefix(wr_prefix),
			.count(count_q),
			.addr(addr_q),
			.tok_in(chain[i]),
			.tok_out(chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			limit_q    <= '0;
			launch_q   <= 1'b0;
			busy_q     <= 1'b0;
			add_done_q <= 1'b0;
		end else begin
			if (entry_limit_we) begin
				limit_q <= entry_limit;
			end
			if (wr.en) begin
				count_q <= count_q + 1'b1;
			end
			launch_q   <= accept && (request.action == ACT_LOOKUP);
			add_done_q <= accept && (request.action == ACT_ADD);
			if (accept && (request.action == ACT_LOOKUP)) begin
				busy_q <= 1'b1;
			end else if (chain[TABLE_DEPTH].valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= ADDR_BITS'(request.address);
			add_ok_q <= !full;
		end
	end

	always_comb begin
		busy = busy_q && !chain[TABLE_DEPTH].valid;
		done = add_done_q || chain[TABLE_DEPTH].valid;
		if (add_done_q) begin
			result.ok                 = add_ok_q;
			result.found_link_address = '0;
			result.found_terminal_id  = '0;
		end else begin
			result.ok                 = chain[TABLE_DEPTH].hit;
			result.found_link_address = chain[TABLE_DEPTH].link;
			result.found_terminal_id  = chain[TABLE_DEPTH].term;
		end
	end

endmodule

/* rtl/lpmt_cell.sv */
// One table entry with its compare stage in the search chain
module lpmt_cell #(
	parameter int ADDR_BITS = lpmt_pkg::DEF_ADDR_BITS,
	parameter int CNT_W = 7,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpmt_pkg::lpmt_wr_t   wr,
	input  logic [ADDR_BITS-1:0] wr_prefix,
	input  logic [CNT_W-1:0]     count,
	input  logic [ADDR_BITS-1:0] addr,
	input  lpmt_pkg::lpmt_tok_t  tok_in,
	output lpmt_pkg::lpmt_tok_t  tok_out
);
	import lpmt_pkg::*;

	logic [ADDR_BITS-1:0] prefix_q;
	logic [LEN_W-1:0]     len_q;
	logic [LINK_W-1:0]    link_q;
	logic [TERM_W-1:0]    term_q;
	lpmt_tok_t            tok_q;

	logic [ADDR_BITS-1:0] mask;
	logic                 live;
	logic                 take;

	always_comb begin
		mask = ~({ADDR_BITS{1'b1}} >> len_q);
		live = CNT_W'(IDX) < count;
		take = tok_in.valid && live && (((prefix_q ^ addr) & mask) == '0)
			&& (len_q >= tok_in.len);
	end

	always_ff @(posedge clk) begin
		if (wr.en && (count == CNT_W'(IDX))) begin
			prefix_q <= wr_prefix;
			len_q    <= wr.len;
			link_q   <= wr.link;
			term_q   <= wr.term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			if (take) begin
				tok_q.hit  <= 1'b1;
				tok_q.len  <= len_q;
				tok_q.link <= link_q;
				tok_q.term <= term_q;
			end else begin
				tok_q.hit  <= tok_in.hit;
				tok_q.len  <= tok_in.len;
				tok_q.link <= tok_in.link;
				tok_q.term <= tok_in.term;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/lpmt_checker.sv */
// Port-level checks of the lookup table, bound to the top level
`include "longest_prefix_match_table_defines.svh"

module lpmt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input lpmt_pkg::lpmt_req_t request,
	input logic                done,
	input lpmt_pkg::lpmt_res_t result
);
	import lpmt_pkg::*;

	logic add_acc;
	logic look_acc;

	assign add_acc  = start && !busy && (request.action == ACT_ADD);
	assign look_acc = start && !busy && (request.action == ACT_LOOKUP);

	`LPMT_ASSERT_NEXT(a_add_result, add_acc, done && (result.found_link_address == '0) && (result.found_terminal_id == '0), "add item gave no clean result")
	`LPMT_ASSERT_NEXT(a_lookup_busy, look_acc, busy && !done, "lookup item not held busy")
	`LPMT_ASSERT_IMP(a_miss_zero, done && !result.ok, (result.found_link_address == '0) && (result.found_terminal_id == '0), "failed result carries data")
	`LPMT_ASSERT_IMP(a_busy_quiet, busy, !done, "result while busy")

endmodule

bind longest_prefix_match_table lpmt_checker u_lpmt_checker (.*);
